>>> hw/rtl/i2c_bus_clear_sequencer_assert.svh
// Assertion macros for the I2C bus clear sequencer.
// Depends on nothing; taken in by the top level with `include.
`ifndef I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH
`define I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/i2cbc_pkg.sv
// Package for the I2C bus clear sequencer: register indexes, reset values,
// status codes and the result beat type. Depends on nothing.
`timescale 1ns / 1ps
package i2cbc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 24;
  localparam int CFG_DATA_WIDTH      = 24;
  localparam int CFG_INDEX_WIDTH     = 3;
  localparam int LEN_WIDTH           = 24;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POWER_UP_WAIT = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLL_INTERVAL = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLL_LIMIT    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_LIMIT   = 3'd4;

  localparam logic [23:0] POWER_UP_WAIT_RESET = 24'd2500000;
  localparam logic [9:0]  HALF_PERIOD_RESET   = 10'd10;
  localparam logic [23:0] POLL_INTERVAL_RESET = 24'd100000;
  localparam logic [7:0]  POLL_LIMIT_RESET    = 8'd20;
  localparam logic [7:0]  PULSE_LIMIT_RESET   = 8'd20;

  localparam logic [1:0] STATUS_CLEARED   = 2'd0;
  localparam logic [1:0] STATUS_SCL_LOW   = 2'd1;
  localparam logic [1:0] STATUS_STRETCH   = 2'd2;
  localparam logic [1:0] STATUS_SDA_STUCK = 2'd3;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       scl_pullup;
    logic       sda_pullup;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

>>> hw/rtl/i2c_bus_clear_sequencer.sv
// I2C bus clear sequencer, one timer tick per input beat.
// A result beat is registered in the output register, or in the skid register while the output stalls.
// Throughput: one beat per cycle while the skid register is empty; the sequencer state advances in one pass.
// Reset (rst, synchronous): idle, counters zero, status 0, registers at defaults.
// Depends on i2cbc_pkg and i2c_bus_clear_sequencer_assert.svh.
`timescale 1ns / 1ps
`include "i2c_bus_clear_sequencer_assert.svh"
module i2c_bus_clear_sequencer #(
  parameter int COUNT_WIDTH = i2cbc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Tick input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  start_req,
  input  logic                                  scl_level,
  input  logic                                  sda_level,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  scl_drive_low,
  output logic                                  sda_drive_low,
  output logic                                  scl_pullup,
  output logic                                  sda_pullup,
  output logic                                  busy_res,
  output logic                                  done_res,
  output logic [1:0]                            status,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [i2cbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [i2cbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  // Phase codes of the sequencer. The one spare code behaves as idle.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_POWER   = 3'd1;
  localparam logic [2:0] PH_LOW     = 3'd2;
  localparam logic [2:0] PH_HIGH    = 3'd3;
  localparam logic [2:0] PH_STRETCH = 3'd4;
  localparam logic [2:0] PH_START   = 3'd5;
  localparam logic [2:0] PH_STOP    = 3'd6;

  localparam int LW   = i2cbc_pkg::LEN_WIDTH;
  // Width large enough to compare a length against the largest count.
  localparam int WIDE = (LW > COUNT_WIDTH) ? LW : COUNT_WIDTH;

  // A length of n ticks loads n-1, a zero length acts as one tick, and a length
  // that does not fit in the counter saturates to its largest value.
  function automatic logic [COUNT_WIDTH-1:0] sat_len(input logic [LW-1:0] len);
    logic [LW-1:0]   v;
    logic [WIDE-1:0] v_w;
    logic [WIDE-1:0] max_w;
    v     = (len == '0) ? '0 : len - LW'(1);
    v_w   = WIDE'(v);
    max_w = WIDE'({COUNT_WIDTH{1'b1}});
    if (v_w > max_w) begin
      v_w = max_w;
    end
    return v_w[COUNT_WIDTH-1:0];
  endfunction

  // Configuration registers.
  logic [23:0] power_up_wait;
  logic [9:0]  half_period;
  logic [23:0] poll_interval;
  logic [7:0]  poll_limit;
  logic [7:0]  pulse_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_wait <= i2cbc_pkg::POWER_UP_WAIT_RESET;
      half_period   <= i2cbc_pkg::HALF_PERIOD_RESET;
      poll_interval <= i2cbc_pkg::POLL_INTERVAL_RESET;
      poll_limit    <= i2cbc_pkg::POLL_LIMIT_RESET;
      pulse_limit   <= i2cbc_pkg::PULSE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cbc_pkg::REG_POWER_UP_WAIT: power_up_wait <= cfg_data;
        i2cbc_pkg::REG_HALF_PERIOD:   half_period   <= cfg_data[9:0];
        i2cbc_pkg::REG_POLL_INTERVAL: poll_interval <= cfg_data;
        i2cbc_pkg::REG_POLL_LIMIT:    poll_limit    <= cfg_data[7:0];
        i2cbc_pkg::REG_PULSE_LIMIT:   pulse_limit   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state.
  logic [2:0]             phase;
  logic [COUNT_WIDTH-1:0] wait_count;
  logic [7:0]             pulses_left;
  logic [7:0]             polls_left;
  logic [1:0]             last_status;

  logic [2:0]             phase_next;
  logic [COUNT_WIDTH-1:0] wait_count_next;
  logic [7:0]             pulses_left_next;
  logic [7:0]             polls_left_next;
  logic [1:0]             last_status_next;
  logic                   finished;
  logic                   check_sda;

  // Counter loads for each kind of timed phase, ready before the decision.
  logic [COUNT_WIDTH-1:0] half_load;
  logic [COUNT_WIDTH-1:0] power_load;
  logic [COUNT_WIDTH-1:0] poll_load;

  assign half_load  = sat_len(LW'(half_period));
  assign power_load = sat_len(power_up_wait);
  assign poll_load  = sat_len(poll_interval);

  // One pass of the sequencer for the current tick. A timed phase counts down
  // while wait_count is nonzero and makes its decision on the tick after the
  // count is spent. Whenever SCL is known to be high, the SDA level decides
  // between another clock pulse, the SDA stuck error, or the START/STOP tail.
  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    pulses_left_next = pulses_left;
    polls_left_next  = polls_left;
    last_status_next = last_status;
    finished         = 1'b0;
    check_sda        = 1'b0;

    if (phase == PH_IDLE || phase > PH_STOP) begin
      phase_next = PH_IDLE;
      if (start_req) begin
        phase_next       = PH_POWER;
        pulses_left_next = pulse_limit;
        polls_left_next  = '0;
        wait_count_next  = power_load;
      end
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - COUNT_WIDTH'(1);
    end else begin
      case (phase)
        PH_POWER: begin
          if (!scl_level) begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbc_pkg::STATUS_SCL_LOW;
            finished         = 1'b1;
          end else begin
            check_sda = 1'b1;
          end
        end
        PH_LOW: begin
          phase_next      = PH_HIGH;
          wait_count_next = half_load;
        end
        PH_HIGH: begin
          if (scl_level) begin
            check_sda = 1'b1;
          end else if (poll_limit == '0) begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbc_pkg::STATUS_STRETCH;
            finished         = 1'b1;
          end else begin
            // A slave holds SCL low: start polling it.
            polls_left_next = poll_limit - 8'd1;
            phase_next      = PH_STRETCH;
            wait_count_next = poll_load;
          end
        end
        PH_STRETCH: begin
          if (scl_level) begin
            check_sda = 1'b1;
          end else if (polls_left == '0) begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbc_pkg::STATUS_STRETCH;
            finished         = 1'b1;
          end else begin
            polls_left_next = polls_left - 8'd1;
            wait_count_next = poll_load;
          end
        end
        PH_START: begin
          phase_next      = PH_STOP;
          wait_count_next = half_load;
        end
        PH_STOP: begin
          phase_next       = PH_IDLE;
          last_status_next = i2cbc_pkg::STATUS_CLEARED;
          finished         = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      if (check_sda) begin
        if (!sda_level) begin
          if (pulses_left != '0) begin
            pulses_left_next = pulses_left - 8'd1;
            phase_next       = PH_LOW;
            wait_count_next  = half_load;
          end else begin
            phase_next       = PH_IDLE;
            last_status_next = i2cbc_pkg::STATUS_SDA_STUCK;
            finished         = 1'b1;
          end
        end else begin
          phase_next      = PH_START;
          wait_count_next = half_load;
        end
      end
    end
  end

  // Line controls follow the phase after the tick. When idle, the pull-ups
  // remain on after a failed sequence so the bus is not left floating.
  i2cbc_pkg::result_t result;

  always_comb begin
    result             = '0;
    result.busy_res    = (phase_next != PH_IDLE);
    result.done_res    = finished;
    result.status      = last_status_next;
    case (phase_next)
      PH_IDLE: begin
        result.scl_pullup = (last_status_next != i2cbc_pkg::STATUS_CLEARED);
        result.sda_pullup = (last_status_next != i2cbc_pkg::STATUS_CLEARED);
      end
      PH_LOW: begin
        result.scl_drive_low = 1'b1;
        result.sda_pullup    = 1'b1;
      end
      PH_START: begin
        result.sda_drive_low = 1'b1;
        result.scl_pullup    = 1'b1;
      end
      default: begin
        result.scl_pullup = 1'b1;
        result.sda_pullup = 1'b1;
      end
    endcase
  end

  // Handshake. The output register and a skid register let the input take a
  // beat while a result waits; input stalls only when the skid is full.
  logic               in_accept;
  logic               skid_valid;
  i2cbc_pkg::result_t skid;
  i2cbc_pkg::result_t out_reg;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_count  <= '0;
      pulses_left <= '0;
      polls_left  <= '0;
      last_status <= i2cbc_pkg::STATUS_CLEARED;
    end else if (in_accept) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      pulses_left <= pulses_left_next;
      polls_left  <= polls_left_next;
      last_status <= last_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (in_accept) begin
        out_reg <= result;
      end
    end else if (in_accept) begin
      skid <= result;
    end
  end

  assign scl_drive_low = out_reg.scl_drive_low;
  assign sda_drive_low = out_reg.sda_drive_low;
  assign scl_pullup    = out_reg.scl_pullup;
  assign sda_pullup    = out_reg.sda_pullup;
  assign busy_res      = out_reg.busy_res;
  assign done_res      = out_reg.done_res;
  assign status        = out_reg.status;

  // The skid register only fills behind a stalled output beat.
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A beat that finishes a sequence shows the block idle again.
  `ASSERT_IMPLIES(a_done_not_busy, clk, rst, out_valid && done_res, !busy_res)
  // SCL is never driven low and pulled up at once.
  `ASSERT_IMPLIES(a_scl_no_fight, clk, rst, out_valid && scl_drive_low, !scl_pullup)
  // A stalled result with a full skid keeps the input closed next cycle.
  `ASSERT_NEXT(a_skid_stall, clk, rst, skid_valid && out_valid && !out_ready, !in_ready)

endmodule
